### design/arnp_pkg.sv
// ----------------------------------------------------------------------------
// arnp_pkg: shared types and constants for the ASCII radix number parser
// Word types for both channels, parse phase encoding, character constants
// and the hex digit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package arnp_pkg;

  // Default sizes for the top level parameters
  localparam int unsigned ValueBitsDef = 64;
  localparam int unsigned CountBitsDef = 16;

  // Fixed field widths of the words
  localparam int unsigned ValueW  = 64;
  localparam int unsigned CountW  = 16;
  localparam int unsigned RadixW  = 5;
  localparam int unsigned HexCntW = 5;

  localparam logic [RadixW-1:0] RadixReset = 5'd10;
  localparam logic [RadixW-1:0] RadixMin   = 5'd2;
  localparam logic [RadixW-1:0] RadixDec   = 5'd10;
  localparam logic [RadixW-1:0] RadixHex   = 5'd16;

  // Character codes
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'
  localparam logic [7:0] ChUpA   = 8'h41;  // 'A'
  localparam logic [7:0] ChUpF   = 8'h46;  // 'F'
  localparam logic [7:0] ChLowA  = 8'h61;  // 'a'
  localparam logic [7:0] ChLowF  = 8'h66;  // 'f'

  // Hex decode result for a character that is not a hex digit
  localparam logic [4:0] HexNone = 5'd16;

  typedef enum logic [1:0] {
    PH_DONE,
    PH_ZEROS,
    PH_DIGITS
  } arnp_phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } arnp_in_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [CountW-1:0] consumed_count;
    logic              saturated;
    logic              bad_radix;
  } arnp_out_t;

  // Hex digit value, HexNone when ch is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [7:0] t;
    t = 8'h00;
    if (ch >= ChZero && ch <= ChNine) begin
      t = ch - ChZero;
      return t[4:0];
    end else if (ch >= ChUpA && ch <= ChUpF) begin
      t = ch - ChUpA + 8'd10;
      return t[4:0];
    end else if (ch >= ChLowA && ch <= ChLowF) begin
      t = ch - ChLowA + 8'd10;
      return t[4:0];
    end
    return HexNone;
  endfunction

endpackage

`default_nettype wire

### design/ascii_radix_number_parser.sv
// ----------------------------------------------------------------------------
// ascii_radix_number_parser: streaming ASCII to unsigned integer converter
// Takes one character per word, skips leading zeros, accumulates digits in
// the configured radix and emits value, consumed count and flags at the
// first character that ends the number.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  in        in   in_valid_i / in_stall_o   in_data_i   (ch, first)
//  out       out  out_valid_o / out_stall_i out_data_o  (value, count, flags)
//  cfg       in   cfg_we_i                  cfg_wdata_i (radix)
//
//  One character per cycle sustained while the result is not stalled. A character
//  is held in the input register, then the digit multiply-add updates the parse
//  state and loads the result register.
//  Reset puts radix at 10 and the parser in the done phase; no clearing pass.
//  A stalled result holds both stages; one more character is still taken
//  into the empty input register.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_radix_number_parser #(
  parameter int unsigned VALUE_BITS = arnp_pkg::ValueBitsDef,
  parameter int unsigned COUNT_BITS = arnp_pkg::CountBitsDef
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  arnp_pkg::arnp_in_t             in_data_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output arnp_pkg::arnp_out_t                  out_data_o,
  input  wire                                  cfg_we_i,
  input  wire  [arnp_pkg::RadixW-1:0]          cfg_wdata_i
);

  localparam int unsigned HexLimit = VALUE_BITS / 4;
  localparam int unsigned ProdW    = VALUE_BITS + 5;

  localparam logic [VALUE_BITS-1:0] ValueMax = {VALUE_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  // Config register
  logic [arnp_pkg::RadixW-1:0] radix_q;

  // Input register
  logic               ival_q;
  arnp_pkg::arnp_in_t idata_q;

  // Parse state
  arnp_pkg::arnp_phase_e            phase_q, phase_d;
  logic [VALUE_BITS-1:0]            acc_q, acc_d;
  logic [COUNT_BITS-1:0]            cnt_q, cnt_d;
  logic [arnp_pkg::HexCntW-1:0]     hcnt_q, hcnt_d;

  // Result register
  logic                oval_q;
  arnp_pkg::arnp_out_t odata_q;

  logic                res_emit;
  arnp_pkg::arnp_out_t res_data;

  // Pipeline control
  logic adv;
  logic proc;

  assign adv        = !oval_q || !out_stall_i;
  assign proc       = ival_q && adv;
  assign in_stall_o = ival_q && !adv;

  // Effective state after an optional start
  arnp_pkg::arnp_phase_e         ph_eff;
  logic [VALUE_BITS-1:0]         acc_eff;
  logic [COUNT_BITS-1:0]         cnt_eff;
  logic [arnp_pkg::HexCntW-1:0]  hcnt_eff;
  logic [COUNT_BITS-1:0]         cnt_inc;

  assign ph_eff   = idata_q.first ? arnp_pkg::PH_ZEROS : phase_q;
  assign acc_eff  = idata_q.first ? '0 : acc_q;
  assign cnt_eff  = idata_q.first ? '0 : cnt_q;
  assign hcnt_eff = idata_q.first ? '0 : hcnt_q;
  assign cnt_inc  = (cnt_eff == CountMax) ? cnt_eff : cnt_eff + 1'b1;

  // Character classification
  logic       is_zero_ch;
  logic       zero_skip;
  logic       in_digits;
  logic       rad_dec;
  logic       rad_hex;
  logic       is_dec_ch;
  logic [3:0] dec_val;
  logic       dec_digit;
  logic [4:0] hex_val;
  logic       hex_digit;
  logic       hex_full;
  logic [7:0] dec_off;

  assign is_zero_ch = (idata_q.ch == arnp_pkg::ChZero);
  assign zero_skip  = (ph_eff == arnp_pkg::PH_ZEROS) && is_zero_ch;
  assign in_digits  = ((ph_eff == arnp_pkg::PH_ZEROS) && !is_zero_ch)
                    || (ph_eff == arnp_pkg::PH_DIGITS);
  assign rad_dec    = (radix_q >= arnp_pkg::RadixMin) && (radix_q <= arnp_pkg::RadixDec);
  assign rad_hex    = (radix_q == arnp_pkg::RadixHex);
  assign is_dec_ch  = (idata_q.ch >= arnp_pkg::ChZero) && (idata_q.ch <= arnp_pkg::ChNine);
  assign dec_off    = idata_q.ch - arnp_pkg::ChZero;
  assign dec_val    = dec_off[3:0];
  assign dec_digit  = is_dec_ch && ({1'b0, dec_val} < radix_q);
  assign hex_val    = arnp_pkg::hex_value(idata_q.ch);
  assign hex_digit  = (hex_val != arnp_pkg::HexNone);
  assign hex_full   = (hcnt_eff >= arnp_pkg::HexCntW'(HexLimit));

  // Digit multiply-add: acc * radix + d as a 4-term shift-add, radix <= 10
  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] dec_sum;
  logic             dec_ovf;

  always_comb begin
    prod = '0;
    for (int b = 0; b < 4; b++) begin
      if (radix_q[b]) begin
        prod = prod + (ProdW'(acc_eff) << b);
      end
    end
  end

  assign dec_sum = prod + ProdW'(dec_val);
  assign dec_ovf = |dec_sum[ProdW-1:VALUE_BITS];

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (proc) begin
      if (zero_skip) begin
        phase_d = arnp_pkg::PH_ZEROS;
      end else if (in_digits) begin
        phase_d = res_emit ? arnp_pkg::PH_DONE : arnp_pkg::PH_DIGITS;
      end else begin
        phase_d = ph_eff;
      end
    end
  end

  // Datapath and result word
  always_comb begin
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    hcnt_d   = hcnt_q;
    res_emit = 1'b0;
    res_data = '{value: arnp_pkg::ValueW'(acc_eff),
                 consumed_count: arnp_pkg::CountW'(cnt_eff),
                 saturated: 1'b0,
                 bad_radix: 1'b0};
    if (proc) begin
      acc_d  = acc_eff;
      cnt_d  = cnt_eff;
      hcnt_d = hcnt_eff;
      if (zero_skip) begin
        cnt_d = cnt_inc;
      end else if (in_digits) begin
        priority if (rad_dec) begin
          if (!dec_digit) begin
            res_emit = 1'b1;
          end else if (dec_ovf) begin
            res_emit           = 1'b1;
            res_data.value     = arnp_pkg::ValueW'(ValueMax);
            res_data.saturated = 1'b1;
          end else begin
            acc_d = dec_sum[VALUE_BITS-1:0];
            cnt_d = cnt_inc;
          end
        end else if (rad_hex) begin
          if (hex_full) begin
            res_emit = 1'b1;
            if (hex_digit) begin
              res_data.value     = arnp_pkg::ValueW'(ValueMax);
              res_data.saturated = 1'b1;
            end
          end else if (!hex_digit) begin
            res_emit = 1'b1;
          end else begin
            acc_d  = (acc_eff << 4) | VALUE_BITS'(hex_val[3:0]);
            hcnt_d = hcnt_eff + 1'b1;
            cnt_d  = cnt_inc;
          end
        end else begin
          res_emit                = 1'b1;
          res_data.value          = '0;
          res_data.consumed_count = '0;
          res_data.bad_radix      = 1'b1;
        end
      end
    end
  end

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= arnp_pkg::RadixReset;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ival_q <= 1'b0;
    end else if (!in_stall_o) begin
      ival_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      idata_q <= in_data_i;
    end
  end

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= arnp_pkg::PH_DONE;
      acc_q   <= '0;
      cnt_q   <= '0;
      hcnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      hcnt_q  <= hcnt_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (adv) begin
      oval_q <= proc && res_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_emit) begin
      odata_q <= res_data;
    end
  end

  assign out_valid_o = oval_q;
  assign out_data_o  = odata_q;

  // Checks
  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_radix |->
      out_data_o.value == '0 && out_data_o.consumed_count == '0 && !out_data_o.saturated)
    else $error("bad radix result carries nonzero fields");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      out_data_o.value == arnp_pkg::ValueW'(ValueMax))
    else $error("saturated result is not all ones");

  a_hex_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q <= arnp_pkg::HexCntW'(HexLimit))
    else $error("hex digit count beyond limit");

  a_result_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && res_emit |=> phase_q == arnp_pkg::PH_DONE)
    else $error("parser not done after a result");

endmodule

`default_nettype wire

### tb/tb_ascii_radix_number_parser.sv
// ----------------------------------------------------------------------------
// tb_ascii_radix_number_parser: self-checking bench for the radix parser
// Drives character words through a bursty sender and drains numbers through
// a randomly stalling receiver. A behavioral parser follows every accepted
// word and predicts each number. A short table of hand-checked strings runs
// first. Random strings follow, a leading-zero run closes the run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ascii_radix_number_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [arnp_pkg::ValueW-1:0] ValueMax = {arnp_pkg::ValueW{1'b1}};
  localparam logic [arnp_pkg::CountW-1:0] CountMax = {arnp_pkg::CountW{1'b1}};
  localparam logic [7:0]        ChNul        = 8'h00;
  localparam int                HexLimit     = 16;
  localparam int                RandomChars  = 450;
  localparam int                ZeroRun      = 24;
  localparam int                SettleCycles = 6;
  localparam int                HoldCycles   = 200;
  localparam longint            CycleLimit   = 2_000_000;

  typedef logic [7:0] text_t[$];

  typedef enum logic {
    ROW_CFG,
    ROW_CHAR
  } row_kind_e;

  // One line of the directed table: a radix write or a character word
  typedef struct packed {
    row_kind_e                   kind;
    logic [arnp_pkg::RadixW-1:0] radix;
    arnp_pkg::arnp_in_t          word;
    logic                        typed;
    arnp_pkg::arnp_out_t         want;
  } plan_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  arnp_pkg::arnp_in_t  in_word   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  arnp_pkg::arnp_out_t out_word;
  logic                cfg_we    = 1'b0;
  logic [arnp_pkg::RadixW-1:0] cfg_wdata = '0;

  // Behavioral parser state, at its reset values
  logic [arnp_pkg::RadixW-1:0]  p_radix = arnp_pkg::RadixReset;
  logic [arnp_pkg::ValueW-1:0]  p_acc   = '0;
  logic [arnp_pkg::CountW-1:0]  p_count = '0;
  logic [arnp_pkg::HexCntW-1:0] p_hexn  = '0;
  arnp_pkg::arnp_phase_e        p_phase = arnp_pkg::PH_DONE;

  arnp_pkg::arnp_out_t pending_numbers[$];
  int        fails      = 0;
  int        burst_left = 0;
  bit        hold_req   = 1'b0;

  ascii_radix_number_parser dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the parser by one character; returns 1 when a number closes
  function automatic bit parse_char(input arnp_pkg::arnp_in_t w,
                                    output arnp_pkg::arnp_out_t res);
    logic [arnp_pkg::ValueW-1:0] d;
    logic [arnp_pkg::ValueW-1:0] val;
    logic [4:0]                  nib;
    bit                          fin;
    bit                          sat;
    bit                          bad;
    res = '0;
    fin = 1'b0;
    sat = 1'b0;
    bad = 1'b0;
    if (w.first) begin
      p_acc   = '0;
      p_count = '0;
      p_hexn  = '0;
      p_phase = arnp_pkg::PH_ZEROS;
    end
    if (p_phase == arnp_pkg::PH_ZEROS) begin
      if (w.ch == arnp_pkg::ChZero) begin
        if (p_count != CountMax) p_count++;
        return 1'b0;
      end
      p_phase = arnp_pkg::PH_DIGITS;
    end
    if (p_phase != arnp_pkg::PH_DIGITS) return 1'b0;
    val = p_acc;
    if (p_radix >= arnp_pkg::RadixMin && p_radix <= arnp_pkg::RadixDec) begin
      d = arnp_pkg::ValueW'(w.ch - arnp_pkg::ChZero);
      if (w.ch < arnp_pkg::ChZero || w.ch > arnp_pkg::ChNine ||
          d >= arnp_pkg::ValueW'(p_radix)) begin
        fin = 1'b1;
      end else if (p_acc > (ValueMax - d) / arnp_pkg::ValueW'(p_radix)) begin
        // exact overflow: the digit is rejected and the value clamps
        fin = 1'b1;
        val = ValueMax;
        sat = 1'b1;
      end else begin
        p_acc = p_acc * arnp_pkg::ValueW'(p_radix) + d;
        if (p_count != CountMax) p_count++;
      end
    end else if (p_radix == arnp_pkg::RadixHex) begin
      if (w.ch >= arnp_pkg::ChZero && w.ch <= arnp_pkg::ChNine)
        nib = 5'(w.ch - arnp_pkg::ChZero);
      else if (w.ch >= arnp_pkg::ChUpA && w.ch <= arnp_pkg::ChUpF)
        nib = 5'(w.ch - arnp_pkg::ChUpA + 8'd10);
      else if (w.ch >= arnp_pkg::ChLowA && w.ch <= arnp_pkg::ChLowF)
        nib = 5'(w.ch - arnp_pkg::ChLowA + 8'd10);
      else nib = arnp_pkg::HexNone;
      if (p_hexn >= arnp_pkg::HexCntW'(HexLimit)) begin
        // digit limit reached: one more hex digit saturates
        fin = 1'b1;
        if (nib != arnp_pkg::HexNone) begin
          val = ValueMax;
          sat = 1'b1;
        end
      end else if (nib == arnp_pkg::HexNone) begin
        fin = 1'b1;
      end else begin
        p_acc  = {p_acc[arnp_pkg::ValueW-5:0], nib[3:0]};
        p_hexn = p_hexn + 1'b1;
        if (p_count != CountMax) p_count++;
      end
    end else begin
      fin = 1'b1;
      val = '0;
      bad = 1'b1;
    end
    if (fin) begin
      res.value          = val;
      res.consumed_count = bad ? '0 : p_count;
      res.saturated      = sat;
      res.bad_radix      = bad;
      p_phase            = arnp_pkg::PH_DONE;
    end
    return fin;
  endfunction

  function automatic plan_row_t cfg_row(input logic [arnp_pkg::RadixW-1:0] r);
    plan_row_t p;
    p       = '0;
    p.kind  = ROW_CFG;
    p.radix = r;
    return p;
  endfunction

  function automatic plan_row_t char_row(input logic [7:0] ch, input logic first);
    plan_row_t p;
    p            = '0;
    p.kind       = ROW_CHAR;
    p.word.ch    = ch;
    p.word.first = first;
    return p;
  endfunction

  function automatic plan_row_t number_row(input logic [7:0] ch, input logic first,
                                           input logic [arnp_pkg::ValueW-1:0] value,
                                           input logic [arnp_pkg::CountW-1:0] count,
                                           input logic sat, input logic bad);
    plan_row_t p;
    p                     = char_row(ch, first);
    p.typed               = 1'b1;
    p.want.value          = value;
    p.want.consumed_count = count;
    p.want.saturated      = sat;
    p.want.bad_radix      = bad;
    return p;
  endfunction

  // Random digit of radix r; any byte when the radix is unsupported
  function automatic logic [7:0] digit_char(input logic [arnp_pkg::RadixW-1:0] r);
    int v;
    if (r == arnp_pkg::RadixHex) begin
      v = $urandom_range(0, 15);
      if (v < 10) return arnp_pkg::ChZero + 8'(v);
      return ($urandom_range(0, 1) ? arnp_pkg::ChUpA : arnp_pkg::ChLowA) + 8'(v - 10);
    end
    if (r >= arnp_pkg::RadixMin && r <= arnp_pkg::RadixDec)
      return arnp_pkg::ChZero + 8'($urandom_range(0, r - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // Digits of the largest value in radix r, most significant first
  function automatic text_t max_text(input logic [arnp_pkg::RadixW-1:0] r);
    text_t                       t;
    logic [arnp_pkg::ValueW-1:0] v;
    logic [arnp_pkg::ValueW-1:0] dv;
    v = ValueMax;
    while (v != 0) begin
      dv = v % arnp_pkg::ValueW'(r);
      t.push_front(dv < 10 ? arnp_pkg::ChZero + 8'(dv) : arnp_pkg::ChUpA + 8'(dv - 10));
      v = v / arnp_pkg::ValueW'(r);
    end
    return t;
  endfunction

  // Mostly decimal and hex, now and then an unsupported radix
  function automatic logic [arnp_pkg::RadixW-1:0] pick_radix();
    logic [arnp_pkg::RadixW-1:0] r;
    case ($urandom_range(0, 9))
      0, 1, 2: r = arnp_pkg::RadixDec;
      3, 4, 5: r = arnp_pkg::RadixHex;
      6:       r = arnp_pkg::RadixMin;
      7:       r = arnp_pkg::RadixW'($urandom_range(arnp_pkg::RadixMin, arnp_pkg::RadixDec));
      8:       r = arnp_pkg::RadixW'($urandom_range(arnp_pkg::RadixMin, 9));
      default: begin
        do r = arnp_pkg::RadixW'($urandom_range(0, 31));
        while ((r >= arnp_pkg::RadixMin && r <= arnp_pkg::RadixDec) ||
               r == arnp_pkg::RadixHex);
      end
    endcase
    return r;
  endfunction

  // Offer one character word, bursts separated by random gaps
  task automatic send_word(input arnp_pkg::arnp_in_t w, input logic typed,
                           input arnp_pkg::arnp_out_t want);
    arnp_pkg::arnp_out_t got;
    bit                  made;
    int                  gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    made = parse_char(w, got);
    if (typed) pending_numbers.push_back(want);
    else if (made) pending_numbers.push_back(got);
    @(negedge clk);
  endtask

  // Quiet the sender and wait until the parser has nothing left in flight
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_numbers.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_radix(input logic [arnp_pkg::RadixW-1:0] r);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    p_radix = r;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver stall pattern, plus one long hold-off on request
  initial begin : stall_pattern
    int run;
    bit stall_now;
    run = 0;
    stall_now = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      if (run == 0) begin
        stall_now = !stall_now;
        if (stall_now) run = $urandom_range(1, 4);
        else run = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      run--;
      out_stall <= stall_now;
    end
  end

  // Compare every delivered number with the oldest prediction
  always @(posedge clk) begin : number_check
    arnp_pkg::arnp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_numbers.size() == 0) begin
        $error("number with none predicted: value %h count %0d", out_word.value,
               out_word.consumed_count);
        fails++;
      end else begin
        want = pending_numbers.pop_front();
        if (out_word.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, out_word.value);
          fails++;
        end
        if (out_word.consumed_count !== want.consumed_count) begin
          $error("consumed_count: expected %0d, got %0d", want.consumed_count,
                 out_word.consumed_count);
          fails++;
        end
        if (out_word.saturated !== want.saturated) begin
          $error("saturated: expected %b, got %b", want.saturated, out_word.saturated);
          fails++;
        end
        if (out_word.bad_radix !== want.bad_radix) begin
          $error("bad_radix: expected %b, got %b", want.bad_radix, out_word.bad_radix);
          fails++;
        end
      end
    end
  end

  initial begin : watchdog
    longint cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    plan_row_t                   plan[$];
    text_t                       text;
    text_t                       body;
    arnp_pkg::arnp_in_t          w;
    logic [arnp_pkg::RadixW-1:0] r;
    int                          n_chars;
    int                          split;
    int                          pick;
    int                          len;
    bit                          known;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Hand-checked strings
    plan = '{
      char_row(8'h78, 1'b0),                                   // 'x', no string open
      char_row(arnp_pkg::ChZero, 1'b1),
      char_row(arnp_pkg::ChZero, 1'b0),
      char_row(arnp_pkg::ChZero + 8'd7, 1'b0),
      char_row(ChNul, 1'b0),
      number_row(8'hFF, 1'b1, 64'd0, 16'd0, 1'b0, 1'b0),       // empty number
      cfg_row(arnp_pkg::RadixHex),
      char_row(arnp_pkg::ChLowF, 1'b1),
      char_row(arnp_pkg::ChUpF, 1'b0),
      char_row(arnp_pkg::ChLowA, 1'b0),
      char_row(arnp_pkg::ChUpA, 1'b0),
      char_row(8'h47, 1'b0),                                   // 'G' ends it
      cfg_row(arnp_pkg::RadixMin),
      char_row(arnp_pkg::ChZero + 8'd1, 1'b1),
      char_row(arnp_pkg::ChZero + 8'd2, 1'b0),
      cfg_row(arnp_pkg::RadixW'(11)),
      char_row(arnp_pkg::ChZero, 1'b1),                        // zeros delay the flag
      number_row(arnp_pkg::ChZero + 8'd5, 1'b0, 64'd0, 16'd0, 1'b0, 1'b1),
      cfg_row(arnp_pkg::RadixW'(0)),
      number_row(ChNul, 1'b1, 64'd0, 16'd0, 1'b0, 1'b1),
      cfg_row(arnp_pkg::RadixW'(31)),
      number_row(arnp_pkg::ChNine, 1'b1, 64'd0, 16'd0, 1'b0, 1'b1),
      // radix switched from decimal to hex in mid-string
      cfg_row(arnp_pkg::RadixDec),
      char_row(arnp_pkg::ChNine, 1'b1),
      cfg_row(arnp_pkg::RadixHex),
      char_row(arnp_pkg::ChLowA, 1'b0),
      char_row(ChNul, 1'b0),
      char_row(arnp_pkg::ChZero + 8'd1, 1'b1),
      char_row(8'h2F, 1'b0)                                    // '/'
    };
    foreach (plan[n]) begin
      if (plan[n].kind == ROW_CFG) set_radix(plan[n].radix);
      else send_word(plan[n].word, plan[n].typed, plan[n].want);
    end

    // Random strings; the receiver starts with a long hold-off
    hold_req = 1'b1;
    n_chars = 0;
    while (n_chars < RandomChars) begin
      if (n_chars == 0 || $urandom_range(0, 4) == 0) set_radix(pick_radix());
      r = p_radix;
      known = (r >= arnp_pkg::RadixMin && r <= arnp_pkg::RadixDec) ||
              r == arnp_pkg::RadixHex;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // noise: raw bytes, now and then a bare restart
        repeat ($urandom_range(1, 4)) begin
          w.ch    = 8'($urandom_range(0, 255));
          w.first = ($urandom_range(0, 3) == 0);
          send_word(w, 1'b0, '0);
          n_chars++;
        end
      end else begin
        text.delete();
        repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0)
          text.push_back(arnp_pkg::ChZero);
        if (pick == 1 && known) begin
          // right at the overflow boundary
          body = max_text(r);
          case ($urandom_range(0, 2))
            1: if (body[$] != arnp_pkg::ChZero) body[$] = body[$] - 8'd1;
            2: begin
              if (r != arnp_pkg::RadixHex && body[$] < arnp_pkg::ChZero + 8'(r - 1))
                body[$] = body[$] + 8'd1;
              else body.push_back(digit_char(r));
            end
            default: ;
          endcase
          text = {text, body};
        end else begin
          if (pick <= 3 && known) begin
            body = max_text(r);
            len = body.size() - 2 + $urandom_range(0, 4);
          end else begin
            len = $urandom_range(1, 6);
          end
          repeat (len) text.push_back(digit_char(r));
        end
        // terminator, sometimes left off so the next start cuts in
        if ($urandom_range(0, 9) != 0) begin
          case ($urandom_range(0, 3))
            0: text.push_back(ChNul);
            1: text.push_back(8'($urandom_range(0, 255)));
            2: begin
              case ($urandom_range(0, 5))
                0: text.push_back(8'h2F);  // '/'
                1: text.push_back(8'h3A);  // ':'
                2: text.push_back(8'h40);  // '@'
                3: text.push_back(8'h47);  // 'G'
                4: text.push_back(8'h60);  // '`'
                default: text.push_back(8'h67);  // 'g'
              endcase
            end
            default: begin
              if (r < arnp_pkg::RadixDec)
                text.push_back(arnp_pkg::ChZero + 8'($urandom_range(r, 9)));
              else text.push_back(ChNul);
            end
          endcase
        end
        split = -1;
        if ($urandom_range(0, 11) == 0 && text.size() > 1)
          split = $urandom_range(1, text.size() - 1);
        foreach (text[i]) begin
          if (i == split) set_radix(pick_radix());
          w.ch    = text[i];
          w.first = (i == 0);
          send_word(w, 1'b0, '0);
        end
        n_chars += text.size();
        // stray bytes after the number
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            w.ch    = 8'($urandom_range(0, 255));
            w.first = 1'b0;
            send_word(w, 1'b0, '0);
            n_chars++;
          end
        end
      end
    end

    // Leading-zero run ahead of a single digit
    set_radix(arnp_pkg::RadixDec);
    for (int k = 0; k < ZeroRun; k++) begin
      w.ch    = arnp_pkg::ChZero;
      w.first = (k == 0);
      send_word(w, 1'b0, '0);
    end
    w.first = 1'b0;
    w.ch    = arnp_pkg::ChZero + 8'd7;
    send_word(w, 1'b0, '0);
    w.ch = ChNul;
    send_word(w, 1'b0, '0);

    settle();
    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
